// ----- hw/rtl/qcrp_pkg.sv -----
// Shared types and constants for the QUIC CID route parser.
`timescale 1ns / 1ps

package qcrp_pkg;

	// Verdict codes
	localparam logic [1:0] VERD_DROP    = 2'd0;
	localparam logic [1:0] VERD_PASS    = 2'd1;
	localparam logic [1:0] VERD_REWRITE = 2'd2;

	localparam int GATHER_W = 32;
	localparam int ROUTE_W  = 17;
	localparam int OFFSET_W = 16;
	localparam int PORT_W   = 16;

	// Divide by 65521: multiply by this, keep the upper word, then one fixup step.
	localparam int             MAGIC_W   = 20;
	localparam logic [19:0]    DIV_MAGIC = 20'd983266;

	localparam logic [PORT_W-1:0] PORT_FIRST_RST  = 16'd80;
	localparam logic [PORT_W-1:0] PORT_SECOND_RST = 16'd443;

	// Register indexes on the configuration port
	localparam logic REG_PORT_FIRST  = 1'b0;
	localparam logic REG_PORT_SECOND = 1'b1;

	// Parse result handed from the parser to the divider stage
	typedef struct packed {
		logic [1:0]          verdict;    // REWRITE here is tentative
		logic [GATHER_W-1:0] gathered;
		logic [OFFSET_W-1:0] udp_offset;
	} qcrp_res_t;

endpackage

// ----- hw/rtl/qcrp_cfg_regs.sv -----
// APB register file holding the two accepted UDP destination ports.
`timescale 1ns / 1ps

module qcrp_cfg_regs import qcrp_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [2:0]        paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready,
	output logic [PORT_W-1:0] port_first,
	output logic [PORT_W-1:0] port_second
);

	logic              wr_en;
	logic [PORT_W-1:0] port_first_q;
	logic [PORT_W-1:0] port_second_q;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			port_first_q  <= PORT_FIRST_RST;
			port_second_q <= PORT_SECOND_RST;
		end else if (wr_en) begin
			// byte-lane bits of the address are ignored on writes
			case (paddr[2])
				REG_PORT_FIRST:  port_first_q  <= pwdata[PORT_W-1:0];
				REG_PORT_SECOND: port_second_q <= pwdata[PORT_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		if (paddr[1:0] == 2'b00) begin
			case (paddr[2])
				REG_PORT_FIRST:  prdata = {16'h0000, port_first_q};
				REG_PORT_SECOND: prdata = {16'h0000, port_second_q};
				default:         prdata = '0;
			endcase
		end
	end

	assign port_first  = port_first_q;
	assign port_second = port_second_q;

endmodule

// ----- hw/rtl/qcrp_parser.sv -----
// Byte-at-a-time header walk: Ethernet, IPv6, option headers, UDP, QUIC CID.
`timescale 1ns / 1ps

module qcrp_parser import qcrp_pkg::*; #(
	parameter int MAX_EXT_HEADERS = 10
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [7:0]        in_byte,
	input  logic              in_last,
	input  logic [PORT_W-1:0] port_first,
	input  logic [PORT_W-1:0] port_second,
	output logic              res_valid,
	input  logic              res_ready,
	output qcrp_res_t         res
);

	localparam int EXT_CNT_W = $clog2(MAX_EXT_HEADERS + 1);

	localparam logic [15:0] ETYPE_IPV6 = 16'h86dd;
	localparam logic [7:0]  NH_HOP     = 8'd0;
	localparam logic [7:0]  NH_ROUTING = 8'd43;
	localparam logic [7:0]  NH_DSTOPT  = 8'd60;
	localparam logic [7:0]  NH_UDP     = 8'd17;
	localparam logic [15:0] POS_ETYPE_HI = 16'd12;
	localparam logic [15:0] POS_ETYPE_LO = 16'd13;
	localparam logic [15:0] POS_NEXT_HDR = 16'd20;
	localparam logic [15:0] POS_IP6_END  = 16'd53;
	localparam logic [15:0] IP6_PAYLOAD  = 16'd54;

	typedef enum logic [4:0] {
		PH_ETH   = 5'b00001,
		PH_IP6   = 5'b00010,
		PH_EXT   = 5'b00100,
		PH_XPORT = 5'b01000,
		PH_DONE  = 5'b10000
	} phase_t;

	// input register
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       last_s1;

	// frame state
	logic [15:0]          pos_q,      pos_n;
	phase_t               phase_q,    phase_n;
	logic [7:0]           nht_q,      nht_n;
	logic [15:0]          hs_q,       hs_n;
	logic [EXT_CNT_W-1:0] ext_cnt_q,  ext_cnt_n;
	logic [7:0]           ext_len_q,  ext_len_n;
	logic [15:0]          dport_q,    dport_n;
	logic                 qlong_q,    qlong_n;
	logic [7:0]           cid_len_q,  cid_len_n;
	logic [GATHER_W-1:0]  gathered_q, gathered_n;
	logic [1:0]           decided_q,  decided_n;
	logic                 gate_q,     gate_n;

	// result register
	logic      valid_s2;
	qcrp_res_t res_s2;

	logic        consume;
	logic [15:0] off;
	logic        at_hdr;
	logic        do_dispatch;
	logic        is_opt;
	logic        do_gather;
	logic [2:0]  gk;
	logic [3:0]  nib;
	logic [1:0]  v_final;
	logic [16:0] gate_end;

	assign consume  = valid_s1 && (!last_s1 || !valid_s2 || res_ready);
	assign in_ready = !valid_s1 || consume;

	assign off    = pos_q - hs_q;
	assign at_hdr = pos_q >= hs_q;
	assign nib    = {byte_s1[6], byte_s1[4], byte_s1[2], byte_s1[0]};
	assign is_opt = (nht_q == NH_HOP || nht_q == NH_ROUTING || nht_q == NH_DSTOPT)
		&& (ext_cnt_q < EXT_CNT_W'(MAX_EXT_HEADERS));

	always_comb begin
		pos_n      = pos_q;
		phase_n    = phase_q;
		nht_n      = nht_q;
		hs_n       = hs_q;
		ext_cnt_n  = ext_cnt_q;
		ext_len_n  = ext_len_q;
		dport_n    = dport_q;
		qlong_n    = qlong_q;
		cid_len_n  = cid_len_q;
		gathered_n = gathered_q;
		decided_n  = decided_q;
		gate_n     = gate_q;
		do_dispatch = 1'b0;
		do_gather   = 1'b0;
		gk          = '0;

		case (phase_q)
			PH_ETH: begin
				if (pos_q == POS_ETYPE_HI) begin
					dport_n = {byte_s1, 8'h00};
				end else if (pos_q == POS_ETYPE_LO) begin
					dport_n = {dport_q[15:8], byte_s1};
					if ({dport_q[15:8], byte_s1} != ETYPE_IPV6) begin
						phase_n   = PH_DONE;
						decided_n = VERD_DROP;
					end else begin
						phase_n = PH_IP6;
					end
				end
			end
			PH_IP6: begin
				if (pos_q == POS_NEXT_HDR) begin
					nht_n = byte_s1;
				end else if (pos_q == POS_IP6_END) begin
					hs_n        = IP6_PAYLOAD;
					do_dispatch = 1'b1;
				end
			end
			PH_EXT: begin
				if (at_hdr) begin
					if (off == 16'd0) begin
						nht_n = byte_s1;
					end else if (off == 16'd1) begin
						ext_len_n = byte_s1;
					end else if (off == 16'd7) begin
						// header length is 8 * (hdrlen + 1) bytes
						hs_n        = hs_q + {5'b0, ext_len_q, 3'b000} + 16'd8;
						do_dispatch = 1'b1;
					end
				end
			end
			PH_XPORT: begin
				if (at_hdr) begin
					if (off == 16'd2) begin
						dport_n = {byte_s1, 8'h00};
					end else if (off == 16'd3) begin
						dport_n = {dport_q[15:8], byte_s1};
					end else if (off == 16'd7) begin
						if (dport_q != port_first && dport_q != port_second) begin
							phase_n   = PH_DONE;
							decided_n = VERD_PASS;
						end
					end else if (off == 16'd8) begin
						qlong_n = byte_s1[7];
						if (!byte_s1[6]) begin
							phase_n   = PH_DONE;
							decided_n = VERD_DROP;
						end
					end else if (!qlong_q) begin
						// short header: DCID starts right after the first byte
						if (off == 16'd9) begin
							if (byte_s1[5:0] < 6'd8) begin
								phase_n   = PH_DONE;
								decided_n = VERD_PASS;
							end
						end else if (off >= 16'd10 && off <= 16'd17) begin
							do_gather = 1'b1;
							gk        = 3'(off - 16'd10);
							if (off == 16'd17) begin
								phase_n   = PH_DONE;
								decided_n = VERD_REWRITE;
							end
						end
					end else begin
						// long header: version, then DCID length, then DCID
						if (off == 16'd13) begin
							cid_len_n = byte_s1;
							if (byte_s1 == 8'd0) begin
								phase_n   = PH_DONE;
								decided_n = VERD_PASS;
							end else begin
								gate_n = 1'b1;
							end
						end else if (off == 16'd14) begin
							if (({2'b00, byte_s1[5:0]} + 8'd1) != cid_len_q
								|| byte_s1[5:0] < 6'd8) begin
								phase_n   = PH_DONE;
								decided_n = VERD_PASS;
							end
						end else if (off >= 16'd15 && off <= 16'd22) begin
							do_gather = 1'b1;
							gk        = 3'(off - 16'd15);
							if (off == 16'd22) begin
								phase_n   = PH_DONE;
								decided_n = VERD_REWRITE;
							end
						end
					end
				end
			end
			default: ;
		endcase

		if (do_gather) begin
			gathered_n = gathered_q | (GATHER_W'(nib) << {gk, 2'b00});
		end

		if (do_dispatch) begin
			if (is_opt) begin
				ext_cnt_n = ext_cnt_q + EXT_CNT_W'(1);
				phase_n   = PH_EXT;
			end else if (nht_q != NH_UDP) begin
				phase_n   = PH_DONE;
				decided_n = VERD_PASS;
			end else begin
				phase_n = PH_XPORT;
			end
		end

		// verdict for a frame that ends on this byte
		v_final  = (phase_n == PH_DONE) ? decided_n : VERD_DROP;
		gate_end = {1'b0, hs_n} + 17'd13 + {9'b0, cid_len_n};
		if (gate_n && ({1'b0, pos_q} < gate_end)) begin
			v_final = VERD_DROP;
		end

		if (!last_s1 && pos_q != 16'hffff) begin
			pos_n = pos_q + 16'd1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			byte_s1 <= in_byte;
			last_s1 <= in_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q      <= '0;
			phase_q    <= PH_ETH;
			nht_q      <= '0;
			hs_q       <= '0;
			ext_cnt_q  <= '0;
			ext_len_q  <= '0;
			dport_q    <= '0;
			qlong_q    <= 1'b0;
			cid_len_q  <= '0;
			gathered_q <= '0;
			decided_q  <= VERD_DROP;
			gate_q     <= 1'b0;
		end else if (consume) begin
			if (last_s1) begin
				pos_q      <= '0;
				phase_q    <= PH_ETH;
				nht_q      <= '0;
				hs_q       <= '0;
				ext_cnt_q  <= '0;
				ext_len_q  <= '0;
				dport_q    <= '0;
				qlong_q    <= 1'b0;
				cid_len_q  <= '0;
				gathered_q <= '0;
				decided_q  <= VERD_DROP;
				gate_q     <= 1'b0;
			end else begin
				pos_q      <= pos_n;
				phase_q    <= phase_n;
				nht_q      <= nht_n;
				hs_q       <= hs_n;
				ext_cnt_q  <= ext_cnt_n;
				ext_len_q  <= ext_len_n;
				dport_q    <= dport_n;
				qlong_q    <= qlong_n;
				cid_len_q  <= cid_len_n;
				gathered_q <= gathered_n;
				decided_q  <= decided_n;
				gate_q     <= gate_n;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (consume && last_s1) begin
			valid_s2 <= 1'b1;
		end else if (res_ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (consume && last_s1) begin
			res_s2.verdict    <= v_final;
			res_s2.gathered   <= gathered_n;
			res_s2.udp_offset <= hs_n;
		end
	end

	assign res_valid = valid_s2;
	assign res       = res_s2;

endmodule

// ----- hw/rtl/qcrp_route_div.sv -----
// Two-stage divide of the gathered CID bits by 65521 and the output register.
`timescale 1ns / 1ps

module qcrp_route_div import qcrp_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  qcrp_res_t           res,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [1:0]          verdict,
	output logic [ROUTE_W-1:0]  route_value,
	output logic [OFFSET_W-1:0] udp_offset
);

	localparam int PROD_W = MAGIC_W + GATHER_W;

	logic                valid_s3;
	logic [GATHER_W-1:0] n_s3;
	logic [MAGIC_W-1:0]  q_s3;
	logic [1:0]          verd_s3;
	logic [OFFSET_W-1:0] hs_s3;

	logic                out_valid_q;
	logic [1:0]          verdict_q;
	logic [ROUTE_W-1:0]  route_q;
	logic [OFFSET_W-1:0] offset_q;

	logic                adv_out;
	logic [PROD_W-1:0]   prod;
	logic [GATHER_W-1:0] diff;
	logic [GATHER_W-1:0] tsum;
	logic [ROUTE_W-1:0]  quot;
	logic                rw;

	assign adv_out  = !out_valid_q || out_ready;
	assign in_ready = !valid_s3 || adv_out;

	assign prod = PROD_W'(DIV_MAGIC) * PROD_W'(res.gathered);

	// n - q never underflows since q < n / 4096 + 1
	assign diff = n_s3 - GATHER_W'(q_s3);
	assign tsum = {1'b0, diff[GATHER_W-1:1]} + GATHER_W'(q_s3);
	assign quot = tsum[GATHER_W-1:15];
	assign rw   = (verd_s3 == VERD_REWRITE) && (quot != '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (in_ready) begin
			valid_s3 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			n_s3    <= res.gathered;
			q_s3    <= prod[PROD_W-1:GATHER_W];
			verd_s3 <= res.verdict;
			hs_s3   <= res.udp_offset;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv_out) begin
			out_valid_q <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_out && valid_s3) begin
			if (rw) begin
				verdict_q <= VERD_REWRITE;
				route_q   <= quot;
				offset_q  <= hs_s3;
			end else begin
				// a zero quotient turns a rewrite into a drop
				verdict_q <= (verd_s3 == VERD_REWRITE) ? VERD_DROP : verd_s3;
				route_q   <= '0;
				offset_q  <= '0;
			end
		end
	end

	assign out_valid   = out_valid_q;
	assign verdict     = verdict_q;
	assign route_value = route_q;
	assign udp_offset  = offset_q;

endmodule

// ----- hw/rtl/quic_cid_route_parser.sv -----
// QUIC connection-ID routing parser: one frame byte per request in, one verdict per frame out.
//
// Input stream: one frame byte per request in s_axis_tdata[7:0], starting at the
// Ethernet header; s_axis_tlast marks the final byte of the frame. Every byte
// but the last produces nothing; the last byte produces exactly one request on
// the output stream carrying verdict, route value and UDP header offset.
// Bytes are taken at one per clock while s_axis_tready is high. Once the last
// byte of a frame is accepted, its result passes through the input register,
// parse/result register, multiply register and output register. The divide by
// 65521 is a 20x32 multiply in its own stage followed by a subtract/add fixup.
// When the receiver holds m_axis_tready low the output register keeps its
// request and the stages behind it fill; s_axis_tready drops only once the
// input register holds a last byte that cannot move on. Non-last bytes keep
// flowing, so a full output register alone does not stop the input.
// The APB port holds the two accepted UDP destination ports (offset 0x0 and
// 0x4); write them only while no frame is in flight.
// Reset clears all pipeline valids and frame state; the port registers return
// to 80 and 443.
`timescale 1ns / 1ps

module quic_cid_route_parser import qcrp_pkg::*; #(
	parameter int MAX_EXT_HEADERS = 10
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [7:0] packet_byte
	input  logic        s_axis_tlast,   // end_of_packet
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [39:0] m_axis_tdata,   // [1:0] verdict, [18:2] route_value,
	                                    // [34:19] udp_offset, [39:35] zero
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	logic [PORT_W-1:0]   port_first;
	logic [PORT_W-1:0]   port_second;
	logic                res_valid;
	logic                res_ready;
	qcrp_res_t           res;
	logic [1:0]          verdict;
	logic [ROUTE_W-1:0]  route_value;
	logic [OFFSET_W-1:0] udp_offset;

	qcrp_cfg_regs u_cfg (
		.clk         (clk),
		.arst_n      (arst_n),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.prdata      (prdata),
		.pready      (pready),
		.port_first  (port_first),
		.port_second (port_second)
	);

	qcrp_parser #(
		.MAX_EXT_HEADERS (MAX_EXT_HEADERS)
	) u_parser (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (s_axis_tvalid),
		.in_ready    (s_axis_tready),
		.in_byte     (s_axis_tdata),
		.in_last     (s_axis_tlast),
		.port_first  (port_first),
		.port_second (port_second),
		.res_valid   (res_valid),
		.res_ready   (res_ready),
		.res         (res)
	);

	qcrp_route_div u_div (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (res_valid),
		.in_ready    (res_ready),
		.res         (res),
		.out_valid   (m_axis_tvalid),
		.out_ready   (m_axis_tready),
		.verdict     (verdict),
		.route_value (route_value),
		.udp_offset  (udp_offset)
	);

	assign m_axis_tdata = {5'b00000, udp_offset, route_value, verdict};

`ifndef ASSERT_OFF
	a_verdict_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (verdict == VERD_DROP || verdict == VERD_PASS
			|| verdict == VERD_REWRITE))
		else $error("unknown verdict code on output");

	a_no_rewrite_no_route: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && verdict != VERD_REWRITE) |-> (route_value == '0 && udp_offset == '0))
		else $error("route fields set without rewrite");

	a_rewrite_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && verdict == VERD_REWRITE) |-> (route_value != '0))
		else $error("rewrite with zero route value");

	a_port_write: assert property (@(posedge clk) disable iff (!arst_n)
		(psel && penable && pwrite && paddr[2] == REG_PORT_FIRST)
			|=> (port_first == $past(pwdata[PORT_W-1:0])))
		else $error("port_first write lost");
`endif

endmodule

// ----- bench/quic_cid_route_parser_tb.sv -----
// Testbench for the QUIC CID route parser: frame stimulus, verdict prediction, result check.
`timescale 1ns / 1ps

module quic_cid_route_parser_tb;
	import qcrp_pkg::*;

	localparam int MAX_EXT      = 10;
	localparam int HOLD_CYCLES  = 300;
	localparam int DRAIN_CYCLES = 8;

	localparam logic [15:0] ETH_IPV6      = 16'h86dd;
	localparam logic [7:0]  NH_HOP_BY_HOP = 8'd0;
	localparam logic [7:0]  NH_ROUTING    = 8'd43;
	localparam logic [7:0]  NH_DEST_OPTS  = 8'd60;
	localparam logic [7:0]  NH_UDP        = 8'd17;
	localparam logic [7:0]  NH_TCP        = 8'd6;

	typedef enum logic [2:0] {ST_ETH, ST_IP6, ST_EXT, ST_XPORT, ST_DONE} parse_st_t;

	typedef struct packed {
		logic [1:0]          verdict;
		logic [ROUTE_W-1:0]  route;
		logic [OFFSET_W-1:0] offset;
	} route_result_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata = 8'h00;
	logic        s_axis_tlast = 1'b0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [39:0] m_axis_tdata;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [2:0]  paddr = 3'd0;
	logic [31:0] pwdata = 32'd0;
	logic [31:0] prdata;
	logic        pready;

	quic_cid_route_parser #(
		.MAX_EXT_HEADERS(MAX_EXT)
	) u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tlast (s_axis_tlast),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Parser mirror: port settings and per-frame state
	logic [15:0] cfg_first, cfg_second;
	parse_st_t   pr_phase;
	logic [15:0] pr_pos, pr_hdr_start, pr_dport;
	logic [7:0]  pr_nh, pr_ext_len, pr_quic0, pr_cid_len, pr_cid_oct;
	logic [3:0]  pr_ext_cnt;
	logic [31:0] pr_gathered;
	logic [1:0]  pr_verdict;
	logic        pr_decided, pr_len_gate;

	route_result_t verdict_q[$];

	// Frame under construction and landmarks inside it
	logic [7:0] frame_q[$];
	int udp_at, quic_at, cid_at, len_at, gather_at;
	int ext_len_lo = 0;
	int ext_len_hi = 2;

	int bytes_sent, frames_sent, longest, port_sets, burst_left;
	int err_count, results_seen;
	int verdict_tally[4];
	int hold_requests, holds_served, hold_left, rx_mode, rx_left;

	route_result_t head_res;
	logic [39:0]   got_word;

	function automatic logic [31:0] div_65521(input logic [31:0] n);
		logic [63:0] prod;
		logic [31:0] hi, t;
		prod = 64'(DIV_MAGIC) * 64'(n);
		hi = prod[63:32];
		t = ((n - hi) >> 1) + hi;
		return t >> 15;
	endfunction

	function automatic logic [7:0] pick_option_type();
		case ($urandom_range(0, 2))
			0: return NH_HOP_BY_HOP;
			1: return NH_ROUTING;
			default: return NH_DEST_OPTS;
		endcase
	endfunction

	task automatic clear_frame_state();
		pr_pos = '0; pr_phase = ST_ETH; pr_nh = '0; pr_hdr_start = '0; pr_ext_cnt = '0;
		pr_dport = '0; pr_quic0 = '0; pr_cid_len = '0; pr_cid_oct = '0; pr_gathered = '0;
		pr_verdict = VERD_DROP; pr_decided = 1'b0; pr_ext_len = '0; pr_len_gate = 1'b0;
	endtask

	task automatic settle_verdict(input logic [1:0] v);
		pr_verdict = v;
		pr_decided = 1'b1;
		pr_phase = ST_DONE;
	endtask

	task automatic next_header();
		if ((pr_nh == NH_HOP_BY_HOP || pr_nh == NH_ROUTING || pr_nh == NH_DEST_OPTS)
				&& pr_ext_cnt < MAX_EXT) begin
			pr_ext_cnt++;
			pr_phase = ST_EXT;
		end else if (pr_nh != NH_UDP) begin
			settle_verdict(VERD_PASS);
		end else begin
			pr_phase = ST_XPORT;
		end
	endtask

	task automatic gather_cid(input int k, input logic [7:0] b);
		pr_gathered |= 32'({b[6], b[4], b[2], b[0]}) << (4 * k);
		if (k == 7)
			settle_verdict(div_65521(pr_gathered) == 0 ? VERD_DROP : VERD_REWRITE);
	endtask

	// off counts from the UDP header start
	task automatic udp_quic_byte(input int unsigned off, input logic [7:0] b);
		int unsigned q;
		int l;
		if (off == 2) pr_dport = {b, 8'h00};
		else if (off == 3) pr_dport[7:0] = b;
		else if (off == 7 && pr_dport != cfg_first && pr_dport != cfg_second)
			settle_verdict(VERD_PASS);
		if (off < 8) return;
		q = off - 8;
		if (q == 0) begin
			pr_quic0 = b;
			if (!b[6]) settle_verdict(VERD_DROP);
		end else if (!pr_quic0[7]) begin
			if (q == 1) begin
				pr_cid_oct = b;
				if (b[5:0] < 8) settle_verdict(VERD_PASS);
			end else if (q <= 9) begin
				gather_cid(q - 2, b);
			end
		end else begin
			if (q == 5) begin
				pr_cid_len = b;
				if (b == 0) settle_verdict(VERD_PASS);
				else pr_len_gate = 1'b1;
			end else if (q == 6) begin
				pr_cid_oct = b;
				l = b[5:0];
				if (l + 1 != pr_cid_len || l < 8) settle_verdict(VERD_PASS);
			end else if (q >= 7 && q <= 14) begin
				gather_cid(q - 7, b);
			end
		end
	endtask

	// Advance the mirror by one accepted byte; the last byte queues the frame verdict
	task automatic track_frame_byte(input logic [7:0] b, input logic last);
		int unsigned p, off;
		logic [1:0] v;
		route_result_t r;
		p = pr_pos;
		if (!pr_decided) begin
			case (pr_phase)
				ST_ETH: begin
					if (p == 12) begin
						pr_dport = {b, 8'h00};
					end else if (p == 13) begin
						pr_dport[7:0] = b;
						if (pr_dport != ETH_IPV6) settle_verdict(VERD_DROP);
						else pr_phase = ST_IP6;
					end
				end
				ST_IP6: begin
					if (p == 20) begin
						pr_nh = b;
					end else if (p == 53) begin
						pr_hdr_start = 16'd54;
						next_header();
					end
				end
				ST_EXT: begin
					if (p >= pr_hdr_start) begin
						off = p - pr_hdr_start;
						if (off == 0) begin
							pr_nh = b;
						end else if (off == 1) begin
							pr_ext_len = b;
						end else if (off == 7) begin
							pr_hdr_start = pr_hdr_start + 16'(8 * (1 + pr_ext_len));
							next_header();
						end
					end
				end
				ST_XPORT: if (p >= pr_hdr_start) udp_quic_byte(p - pr_hdr_start, b);
				default: ;
			endcase
		end
		if (!last) begin
			if (pr_pos != 16'hffff) pr_pos++;
			return;
		end
		v = pr_decided ? pr_verdict : VERD_DROP;
		if (pr_len_gate && p < 32'(pr_hdr_start) + 13 + 32'(pr_cid_len)) v = VERD_DROP;
		r.verdict = v;
		r.route = (v == VERD_REWRITE) ? ROUTE_W'(div_65521(pr_gathered)) : '0;
		r.offset = (v == VERD_REWRITE) ? pr_hdr_start : '0;
		verdict_q.push_back(r);
		clear_frame_state();
	endtask

	// Sender: bursts of random length with random gaps
	task automatic send_byte(input logic [7:0] b, input logic last);
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= b;
		s_axis_tlast <= last;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		track_frame_byte(b, last);
		bytes_sent++;
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
			burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
			                                         : $urandom_range(0, 24);
		end
	endtask

	task automatic send_frame();
		int i;
		for (i = 0; i < frame_q.size(); i++)
			send_byte(frame_q[i], i == frame_q.size() - 1);
		frames_sent++;
		if (frame_q.size() > longest) longest = frame_q.size();
	endtask

	task automatic trim_frame(input int n);
		while (frame_q.size() > n) void'(frame_q.pop_back());
	endtask

	// Well-formed frame: Ethernet, IPv6, n_ext option headers, UDP, QUIC with cid_n in the
	// low six bits of the first DCID octet
	task automatic build_frame(input int n_ext, input bit long_hdr, input logic [15:0] dport,
			input int cid_n);
		logic [7:0] nh;
		int i, k, hl;
		frame_q.delete();
		repeat (12) frame_q.push_back(8'($urandom));
		frame_q.push_back(ETH_IPV6[15:8]);
		frame_q.push_back(ETH_IPV6[7:0]);
		nh = (n_ext > 0) ? pick_option_type() : NH_UDP;
		for (i = 0; i < 40; i++) frame_q.push_back(i == 6 ? nh : 8'($urandom));
		for (k = 0; k < n_ext; k++) begin
			nh = (k == n_ext - 1) ? NH_UDP : pick_option_type();
			hl = $urandom_range(ext_len_lo, ext_len_hi);
			frame_q.push_back(nh);
			frame_q.push_back(8'(hl));
			repeat (6 + 8 * hl) frame_q.push_back(8'($urandom));
		end
		udp_at = frame_q.size();
		repeat (2) frame_q.push_back(8'($urandom));
		frame_q.push_back(dport[15:8]);
		frame_q.push_back(dport[7:0]);
		repeat (4) frame_q.push_back(8'($urandom));
		quic_at = frame_q.size();
		if (!long_hdr) begin
			frame_q.push_back((8'($urandom) & 8'h3f) | 8'h40);
			cid_at = frame_q.size();
			len_at = cid_at;
			frame_q.push_back({2'($urandom), 6'(cid_n)});
			gather_at = frame_q.size();
			repeat (8) frame_q.push_back(8'($urandom));
		end else begin
			frame_q.push_back((8'($urandom) & 8'h3f) | 8'hc0);
			repeat (4) frame_q.push_back(8'($urandom));
			len_at = frame_q.size();
			frame_q.push_back(8'(cid_n + 1));
			cid_at = frame_q.size();
			frame_q.push_back({2'($urandom), 6'(cid_n)});
			gather_at = frame_q.size();
			repeat (cid_n) frame_q.push_back(8'($urandom));
		end
		repeat ($urandom_range(0, 8)) frame_q.push_back(8'($urandom));
	endtask

	task automatic make_random_frame();
		bit long_h;
		logic [15:0] dport;
		int n_ext, cid_n, i;
		long_h = 1'($urandom_range(0, 1));
		dport = $urandom_range(0, 1) ? cfg_first : cfg_second;
		n_ext = ($urandom_range(0, 4) == 0) ? $urandom_range(3, MAX_EXT) : $urandom_range(0, 2);
		cid_n = ($urandom_range(0, 3) == 0) ? $urandom_range(8, 63) : $urandom_range(8, 16);
		build_frame(n_ext, long_h, dport, cid_n);
		if ($urandom_range(0, 99) < 40) begin
			case ($urandom_range(0, 9))
				0: frame_q[$urandom_range(12, 13)] = 8'($urandom);
				1: frame_q[20] = 8'($urandom);
				2: begin
					frame_q[udp_at + 2] = 8'($urandom);
					frame_q[udp_at + 3] = 8'($urandom);
				end
				3: frame_q[quic_at] = frame_q[quic_at] ^ 8'h40;
				4: frame_q[cid_at] = {2'($urandom), 6'($urandom_range(0, 7))};
				5: frame_q[len_at] = 8'($urandom);
				6: trim_frame($urandom_range(1, frame_q.size() - 1));
				7: build_frame($urandom_range(MAX_EXT + 1, MAX_EXT + 3), long_h, dport, cid_n);
				8: begin
					// mostly odd bits: tiny or zero quotient
					for (i = 0; i < 8; i++) frame_q[gather_at + i] = 8'($urandom) & 8'haa;
					frame_q[gather_at + $urandom_range(0, 7)] = 8'($urandom);
				end
				default: begin
					frame_q.delete();
					repeat ($urandom_range(1, 90)) frame_q.push_back(8'($urandom));
				end
			endcase
		end
	endtask

	task automatic sender_quiet();
		s_axis_tvalid <= 1'b0;
	endtask

	// Nothing in flight: all verdicts back plus the pipeline depth
	task automatic settle_block();
		sender_quiet();
		while (verdict_q.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic apb_write(input logic idx, input logic [15:0] val);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= {16'($urandom), val};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		if (idx == REG_PORT_FIRST) cfg_first = val;
		else cfg_second = val;
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic apb_read(input logic idx, input logic [15:0] want);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= {idx, 2'b00};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		if (prdata !== {16'h0000, want}) begin
			if (err_count < 10)
				$display("port register %0d read: expected %0d, got %0h", idx, want, prdata);
			err_count++;
		end
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic configure_ports(input logic [15:0] first_port, input logic [15:0] second_port);
		settle_block();
		apb_write(REG_PORT_FIRST, first_port);
		apb_write(REG_PORT_SECOND, second_port);
		apb_read(REG_PORT_FIRST, first_port);
		apb_read(REG_PORT_SECOND, second_port);
		port_sets++;
	endtask

	task automatic test_directed_cases();
		int i;
		// lone byte that is also the last
		frame_q.delete();
		frame_q.push_back(8'hff);
		send_frame();
		// short header, every gathered bit set: largest route value
		build_frame(0, 1'b0, cfg_first, 8);
		for (i = 0; i < 8; i++) frame_q[gather_at + i] = 8'hff;
		send_frame();
		// gathered bits all clear: zero quotient drops
		build_frame(0, 1'b0, cfg_second, 63);
		for (i = 0; i < 8; i++) frame_q[gather_at + i] = 8'h00;
		send_frame();
		build_frame(1, 1'b1, cfg_second, 8);
		send_frame();
		// wrong EtherType; the rest of the frame is ignored
		build_frame(0, 1'b0, cfg_first, 9);
		frame_q[12] = 8'h08;
		frame_q[13] = 8'h00;
		send_frame();
		build_frame(0, 1'b0, cfg_first, 9);
		frame_q[20] = NH_TCP;
		send_frame();
		build_frame(0, 1'b1, cfg_first + 16'd1, 9);
		send_frame();
		build_frame(0, 1'b0, cfg_first, 10);
		frame_q[quic_at] = frame_q[quic_at] & 8'hbf;
		send_frame();
		build_frame(0, 1'b0, cfg_first, 8);
		frame_q[cid_at] = 8'hc7;
		send_frame();
		build_frame(0, 1'b1, cfg_first, 8);
		frame_q[len_at] = 8'h00;
		send_frame();
		// length byte disagrees with first DCID octet
		build_frame(0, 1'b1, cfg_second, 12);
		frame_q[len_at] = 8'd12;
		frame_q.push_back(8'h5a);
		send_frame();
		// lengths agree but DCID shorter than 8
		build_frame(0, 1'b1, cfg_first, 8);
		frame_q[len_at] = 8'd6;
		frame_q[cid_at] = 8'h05;
		send_frame();
		// DCID runs one byte past the end after a rewrite was decided
		build_frame(0, 1'b1, cfg_first, 20);
		trim_frame(udp_at + 34);
		send_frame();
		// length byte 255 must read as unsigned
		build_frame(0, 1'b1, cfg_second, 8);
		frame_q[len_at] = 8'hff;
		send_frame();
		build_frame(0, 1'b0, cfg_first, 8);
		trim_frame(30);
		send_frame();
		build_frame(0, 1'b0, cfg_first, 8);
		trim_frame(gather_at + 4);
		send_frame();
		// minimal option headers keep the chain-limit frames short
		ext_len_hi = 0;
		build_frame(MAX_EXT, 1'b0, cfg_first, 8);
		send_frame();
		build_frame(MAX_EXT + 1, 1'b0, cfg_first, 8);
		send_frame();
		ext_len_lo = 9;
		ext_len_hi = 9;
		build_frame(1, 1'b1, cfg_second, 9);
		ext_len_lo = 0;
		ext_len_hi = 2;
		send_frame();
	endtask

	task automatic test_port_extremes();
		configure_ports(16'h0000, 16'hffff);
		build_frame(0, 1'b0, 16'h0000, 8);
		send_frame();
		build_frame(1, 1'b1, 16'hffff, 9);
		send_frame();
		build_frame(0, 1'b0, PORT_FIRST_RST, 8);
		send_frame();
	endtask

	task automatic test_random_traffic(input int byte_goal, input int frame_goal);
		int b0, f0;
		b0 = bytes_sent;
		f0 = frames_sent;
		while (bytes_sent - b0 < byte_goal || frames_sent - f0 < frame_goal) begin
			make_random_frame();
			send_frame();
		end
	endtask

	// Receiver holds off long enough for the pipeline to back up into the input
	task automatic test_output_stall();
		int i;
		hold_requests++;
		for (i = 0; i < 20; i++) begin
			if (i % 10 == 9) begin
				make_random_frame();
			end else begin
				frame_q.delete();
				repeat ($urandom_range(1, 4)) frame_q.push_back(8'($urandom));
			end
			send_frame();
		end
	endtask

	// Receiver: own stall pattern, plus counted hold-offs on request
	always @(posedge clk) begin
		if (holds_served != hold_requests) begin
			holds_served = hold_requests;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left != 0) begin
			hold_left--;
			m_axis_tready <= 1'b0;
		end else begin
			if (rx_left == 0) begin
				rx_mode = $urandom_range(0, 3);
				rx_left = $urandom_range(20, 120);
			end
			rx_left--;
			case (rx_mode)
				0: m_axis_tready <= 1'b1;
				1: m_axis_tready <= ($urandom_range(0, 3) != 0);
				2: m_axis_tready <= ($urandom_range(0, 3) == 0);
				default: m_axis_tready <= ~m_axis_tready;
			endcase
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got_word = m_axis_tdata;
			results_seen++;
			if (verdict_q.size() == 0) begin
				if (err_count < 10)
					$display("unexpected result: verdict=%0d route=%0d off=%0d",
						got_word[1:0], got_word[18:2], got_word[34:19]);
				err_count++;
			end else begin
				head_res = verdict_q.pop_front();
				if (got_word[1:0] !== head_res.verdict || got_word[18:2] !== head_res.route
						|| got_word[34:19] !== head_res.offset || got_word[39:35] !== 5'd0) begin
					if (err_count < 10)
						$display("result %0d: expected v=%0d route=%0d off=%0d, ",
							results_seen, head_res.verdict, head_res.route, head_res.offset,
							"got v=%0d route=%0d off=%0d pad=%0h",
							got_word[1:0], got_word[18:2], got_word[34:19], got_word[39:35]);
					err_count++;
				end
				verdict_tally[head_res.verdict]++;
			end
		end
	end

	initial begin
		#400_000;
		$display("timeout with %0d verdicts outstanding", verdict_q.size());
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	initial begin
		cfg_first = PORT_FIRST_RST;
		cfg_second = PORT_SECOND_RST;
		clear_frame_state();
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed_cases();
		test_port_extremes();
		test_random_traffic(100, 1);
		configure_ports(16'($urandom), 16'($urandom));
		test_random_traffic(100, 1);
		test_output_stall();
		configure_ports(16'hffff, 16'h0000);
		test_random_traffic(100, 1);
		configure_ports(PORT_FIRST_RST, PORT_SECOND_RST);
		test_random_traffic(60, 1);

		settle_block();
		repeat (20) @(posedge clk);
		$display("%0d frames, %0d bytes checked: %0d drop, %0d pass, %0d rewrite",
			frames_sent, bytes_sent, verdict_tally[VERD_DROP], verdict_tally[VERD_PASS],
			verdict_tally[VERD_REWRITE]);
		$display("%0d port settings, %0d output hold-offs, longest frame %0d bytes, %0d errors",
			port_sets, hold_requests, longest, err_count);
		if (err_count == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

// ----- quic_cid_route_parser.f -----
hw/rtl/qcrp_pkg.sv
hw/rtl/qcrp_cfg_regs.sv
hw/rtl/qcrp_parser.sv
hw/rtl/qcrp_route_div.sv
hw/rtl/quic_cid_route_parser.sv
bench/quic_cid_route_parser_tb.sv
